[sv/pac_pkg.sv]
// Shared types and constants for the pointer acceleration and clamp block.
// No dependencies; every other file of the block uses it.
package pac_pkg;

  // Request codes carried in req_type. The fourth code leaves all state alone.
  typedef enum logic [1:0] {
    REQ_MOVE   = 2'd0,
    REQ_SET    = 2'd1,
    REQ_CENTER = 2'd2
  } req_kind_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN      = 3'd0,
    CFG_THRESHOLD = 3'd1,
    CFG_LEFT      = 3'd2,
    CFG_RIGHT     = 3'd3,
    CFG_TOP       = 3'd4,
    CFG_BOTTOM    = 3'd5
  } cfg_reg_t;

  localparam int GAIN_W   = 4;
  localparam int THRESH_W = 8;
  localparam int MOVE_W   = 9;
  localparam int BTN_W    = 8;
  // Largest accelerated magnitude is 0 + 256 * 15 = 3840 (threshold 0, gain 15).
  localparam int ACC_W    = 12;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 4'd2;
  localparam logic [THRESH_W-1:0] THRESH_RST = 8'd5;
  localparam int LEFT_RST   = 0;
  localparam int RIGHT_RST  = 1024;
  localparam int TOP_RST    = 0;
  localparam int BOTTOM_RST = 768;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [THRESH_W-1:0] threshold;
  } accel_cfg_t;

endpackage

[sv/pac_req_if.sv]
// Request channel of the pointer block: valid/ready plus one request.
// Depends on pac_pkg for field widths.
interface pac_req_if #(parameter int COORD_BITS = 12) ();
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            req_type;
  logic signed [pac_pkg::MOVE_W-1:0]     move_dx;
  logic signed [pac_pkg::MOVE_W-1:0]     move_dy;
  logic [pac_pkg::BTN_W-1:0]             button_bits;
  logic signed [COORD_BITS:0]            pos_x;
  logic signed [COORD_BITS:0]            pos_y;

  modport source (output valid, req_type, move_dx, move_dy, button_bits, pos_x, pos_y,
                  input ready);
  modport sink   (input valid, req_type, move_dx, move_dy, button_bits, pos_x, pos_y,
                  output ready);
endinterface

[sv/pac_rsp_if.sv]
// Result channel of the pointer block: valid/ready plus position and buttons.
// Depends on pac_pkg for field widths.
interface pac_rsp_if #(parameter int COORD_BITS = 12) ();
  logic                         valid;
  logic                         ready;
  logic [COORD_BITS-1:0]        out_x;
  logic [COORD_BITS-1:0]        out_y;
  logic [pac_pkg::BTN_W-1:0]    out_buttons;

  modport source (output valid, out_x, out_y, out_buttons, input ready);
  modport sink   (input valid, out_x, out_y, out_buttons, output ready);
endinterface

[sv/pac_cfg_regs.sv]
// Configuration register file: gain, threshold and the four limits.
// Depends on pac_pkg.
module pac_cfg_regs #(
  parameter int COORD_BITS = 12,
  parameter int CFG_W      = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pac_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_W-1:0]                cfg_wdata,
  output pac_pkg::accel_cfg_t             accel,
  output logic [COORD_BITS-1:0]           left_limit,
  output logic [COORD_BITS-1:0]           right_limit,
  output logic [COORD_BITS-1:0]           top_limit,
  output logic [COORD_BITS-1:0]           bottom_limit
);
  import pac_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel.gain      <= GAIN_RST;
      accel.threshold <= THRESH_RST;
      left_limit      <= COORD_BITS'(LEFT_RST);
      right_limit     <= COORD_BITS'(RIGHT_RST);
      top_limit       <= COORD_BITS'(TOP_RST);
      bottom_limit    <= COORD_BITS'(BOTTOM_RST);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GAIN:      accel.gain      <= cfg_wdata[GAIN_W-1:0];
        CFG_THRESHOLD: accel.threshold <= cfg_wdata[THRESH_W-1:0];
        CFG_LEFT:      left_limit      <= cfg_wdata[COORD_BITS-1:0];
        CFG_RIGHT:     right_limit     <= cfg_wdata[COORD_BITS-1:0];
        CFG_TOP:       top_limit       <= cfg_wdata[COORD_BITS-1:0];
        CFG_BOTTOM:    bottom_limit    <= cfg_wdata[COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end
endmodule

[sv/pac_axis.sv]
// Next position of one axis: threshold acceleration, absolute set, recenter,
// then clamp (lower limit first, upper limit wins); the unused code keeps cur. Depends on pac_pkg.
module pac_axis #(
  parameter int COORD_BITS = 12
) (
  input  logic [1:0]                        req_type,
  input  pac_pkg::accel_cfg_t               accel,
  input  logic [COORD_BITS-1:0]             lo,
  input  logic [COORD_BITS-1:0]             hi,
  input  logic [COORD_BITS-1:0]             cur,
  input  logic signed [pac_pkg::MOVE_W-1:0] delta,
  input  logic signed [COORD_BITS:0]        abs_pos,
  output logic [COORD_BITS-1:0]             nxt
);
  import pac_pkg::*;

  localparam int WIDE  = (COORD_BITS > ACC_W) ? COORD_BITS : ACC_W;
  localparam int SUM_W = WIDE + 2;

  logic                     neg;
  logic [MOVE_W-1:0]        mag;
  logic [MOVE_W-1:0]        excess;
  logic [MOVE_W+GAIN_W-1:0] scaled;
  logic [ACC_W-1:0]         acc_mag;
  logic signed [SUM_W-1:0]  acc_s;
  logic [COORD_BITS:0]      mid_sum;
  logic signed [SUM_W-1:0]  cand;
  logic signed [SUM_W-1:0]  lo_s;
  logic signed [SUM_W-1:0]  hi_s;
  logic signed [SUM_W-1:0]  raised;
  logic signed [SUM_W-1:0]  clamped;

  // magnitude fits 9 unsigned bits, including 256
  assign neg    = delta[MOVE_W-1];
  assign mag    = neg ? MOVE_W'(-delta) : MOVE_W'(delta);
  assign excess = mag - MOVE_W'(accel.threshold);
  assign scaled = (MOVE_W+GAIN_W)'(excess) * (MOVE_W+GAIN_W)'(accel.gain);

  always_comb begin
    if (mag > MOVE_W'(accel.threshold)) begin
      acc_mag = ACC_W'(scaled) + ACC_W'(accel.threshold);
    end else begin
      acc_mag = ACC_W'(mag);
    end
  end

  assign acc_s   = neg ? -$signed(SUM_W'(acc_mag)) : $signed(SUM_W'(acc_mag));
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign lo_s    = $signed(SUM_W'(lo));
  assign hi_s    = $signed(SUM_W'(hi));

  always_comb begin
    case (req_type)
      REQ_MOVE:   cand = $signed(SUM_W'(cur)) + acc_s;
      REQ_SET:    cand = SUM_W'(abs_pos);
      REQ_CENTER: cand = $signed(SUM_W'(mid_sum[COORD_BITS:1]));
      default:    cand = $signed(SUM_W'(cur));
    endcase
  end

  assign raised  = (cand < lo_s) ? lo_s : cand;
  assign clamped = (raised > hi_s) ? hi_s : raised;

  // the unused code leaves the position untouched, no clamp
  always_comb begin
    case (req_type)
      REQ_MOVE, REQ_SET, REQ_CENTER: nxt = clamped[COORD_BITS-1:0];
      default:                       nxt = cur;
    endcase
  end
endmodule

[sv/pointer_accel_clamp.sv]
// Top level of the pointer tracker: input register, per-axis update, result register.
// Depends on pac_pkg, pac_req_if, pac_rsp_if, pac_cfg_regs and pac_axis.
//
//  port    | dir | handshake          | carries
//  --------+-----+--------------------+-----------------------------------------------
//  req     | in  | valid/ready        | req_type, move_dx, move_dy, button_bits, pos_x/y
//  rsp     | out | valid/ready        | out_x, out_y, out_buttons
//  cfg_*   | in  | cfg_we, no stall   | cfg_idx selects register, cfg_wdata its value
//
// One request per cycle sustained while rsp is not stalled; rsp.valid rises when an accepted request moves on.
// Requests are registered, the new position is computed from the stored pointer state
// in one pass, and pointer state and the result register load on the same edge, so the
// next request sees the updated position. A stalled rsp holds its result while one more
// request waits in the input register; req.ready drops only when both are full.
// Synchronous reset clears the valid flags and the pointer state, and loads the
// register defaults (gain 2, threshold 5, limits 0..1024 by 0..768).
module pointer_accel_clamp #(
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pac_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [((COORD_BITS > pac_pkg::THRESH_W) ? COORD_BITS : pac_pkg::THRESH_W)-1:0]
                                         cfg_wdata,
  pac_req_if.sink                        req,
  pac_rsp_if.source                      rsp
);
  import pac_pkg::*;

  localparam int CFG_W = (COORD_BITS > THRESH_W) ? COORD_BITS : THRESH_W;

  // configuration
  accel_cfg_t            accel;
  logic [COORD_BITS-1:0] left_limit;
  logic [COORD_BITS-1:0] right_limit;
  logic [COORD_BITS-1:0] top_limit;
  logic [COORD_BITS-1:0] bottom_limit;

  // input register
  logic                     s1_valid;
  logic [1:0]               s1_type;
  logic signed [MOVE_W-1:0] s1_dx;
  logic signed [MOVE_W-1:0] s1_dy;
  logic [BTN_W-1:0]         s1_buttons;
  logic signed [COORD_BITS:0] s1_pos_x;
  logic signed [COORD_BITS:0] s1_pos_y;

  // pointer state
  logic [COORD_BITS-1:0] pointer_x;
  logic [COORD_BITS-1:0] pointer_y;
  logic [BTN_W-1:0]      button_state;
  logic [COORD_BITS-1:0] pointer_x_next;
  logic [COORD_BITS-1:0] pointer_y_next;
  logic [BTN_W-1:0]      button_state_next;

  // result register
  logic                  o_valid;
  logic [COORD_BITS-1:0] o_x;
  logic [COORD_BITS-1:0] o_y;
  logic [BTN_W-1:0]      o_buttons;

  logic advance;
  logic s1_load;

  pac_cfg_regs #(
    .COORD_BITS (COORD_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .accel        (accel),
    .left_limit   (left_limit),
    .right_limit  (right_limit),
    .top_limit    (top_limit),
    .bottom_limit (bottom_limit)
  );

  // request moves to the result register when that one is empty or being drained
  assign advance   = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign s1_load   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_type    <= req.req_type;
      s1_dx      <= req.move_dx;
      s1_dy      <= req.move_dy;
      s1_buttons <= req.button_bits;
      s1_pos_x   <= req.pos_x;
      s1_pos_y   <= req.pos_y;
    end
  end

  pac_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .req_type (s1_type),
    .accel    (accel),
    .lo       (left_limit),
    .hi       (right_limit),
    .cur      (pointer_x),
    .delta    (s1_dx),
    .abs_pos  (s1_pos_x),
    .nxt      (pointer_x_next)
  );

  pac_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .req_type (s1_type),
    .accel    (accel),
    .lo       (top_limit),
    .hi       (bottom_limit),
    .cur      (pointer_y),
    .delta    (s1_dy),
    .abs_pos  (s1_pos_y),
    .nxt      (pointer_y_next)
  );

  // only a move updates the buttons
  assign button_state_next = (s1_type == REQ_MOVE) ? s1_buttons : button_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_x    <= '0;
      pointer_y    <= '0;
      button_state <= '0;
    end else if (advance) begin
      pointer_x    <= pointer_x_next;
      pointer_y    <= pointer_y_next;
      button_state <= button_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_x       <= pointer_x_next;
      o_y       <= pointer_y_next;
      o_buttons <= button_state_next;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.out_x       = o_x;
  assign rsp.out_y       = o_y;
  assign rsp.out_buttons = o_buttons;
endmodule

[dv/pac_checker.sv]
`timescale 1ns / 100ps
// Result checker for pointer_accel_clamp: tracks register writes, predicts each result.
// Depends on pac_pkg and the pac_req_if / pac_rsp_if channel interfaces.
module pac_checker #(
  parameter int COORD_BITS = 12,
  parameter int CFG_W      = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pac_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]             cfg_wdata,
  pac_req_if                           req,
  pac_rsp_if                           rsp,
  output int                           mismatches,
  output int                           pending
);
  import pac_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [BTN_W-1:0]      buttons;
  } pointer_pos_t;

  // shadow registers
  logic [GAIN_W-1:0]     gain;
  logic [THRESH_W-1:0]   thresh;
  logic [COORD_BITS-1:0] left, right, top, bottom;
  // shadow pointer state
  logic [COORD_BITS-1:0] ptr_x, ptr_y;
  logic [BTN_W-1:0]      btn_state;

  pointer_pos_t expected_pos_q[$];
  int           fails;

  function automatic int boost(int d);
    int mag;
    mag = (d < 0) ? -d : d;
    if (mag > int'(thresh))
      mag = int'(thresh) + (mag - int'(thresh)) * int'(gain);
    return (d < 0) ? -mag : mag;
  endfunction

  // lower bound first, so the upper bound wins on crossed limits
  function automatic logic [COORD_BITS-1:0] fence(int v, int lo, int hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic pointer_pos_t advance_pointer(
    logic [1:0] kind,
    logic signed [MOVE_W-1:0] dx, logic signed [MOVE_W-1:0] dy,
    logic [BTN_W-1:0] btn,
    logic signed [COORD_BITS:0] px, logic signed [COORD_BITS:0] py
  );
    int mx, my;
    case (kind)
      REQ_MOVE: begin
        ptr_x = fence(int'(ptr_x) + boost(int'(dx)), int'(left), int'(right));
        ptr_y = fence(int'(ptr_y) + boost(int'(dy)), int'(top), int'(bottom));
        btn_state = btn;
      end
      REQ_SET: begin
        ptr_x = fence(int'(px), int'(left), int'(right));
        ptr_y = fence(int'(py), int'(top), int'(bottom));
      end
      REQ_CENTER: begin
        mx = (int'(left) + int'(right)) / 2;
        my = (int'(top) + int'(bottom)) / 2;
        ptr_x = fence(mx, int'(left), int'(right));
        ptr_y = fence(my, int'(top), int'(bottom));
      end
      default: ;
    endcase
    return '{x: ptr_x, y: ptr_y, buttons: btn_state};
  endfunction

  always @(posedge clk) begin
    pointer_pos_t got, want;
    if (rst) begin
      gain      = GAIN_RST;
      thresh    = THRESH_RST;
      left      = COORD_BITS'(LEFT_RST);
      right     = COORD_BITS'(RIGHT_RST);
      top       = COORD_BITS'(TOP_RST);
      bottom    = COORD_BITS'(BOTTOM_RST);
      ptr_x     = '0;
      ptr_y     = '0;
      btn_state = '0;
      fails     = 0;
      expected_pos_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          CFG_GAIN:      gain   = cfg_wdata[GAIN_W-1:0];
          CFG_THRESHOLD: thresh = cfg_wdata[THRESH_W-1:0];
          CFG_LEFT:      left   = cfg_wdata[COORD_BITS-1:0];
          CFG_RIGHT:     right  = cfg_wdata[COORD_BITS-1:0];
          CFG_TOP:       top    = cfg_wdata[COORD_BITS-1:0];
          CFG_BOTTOM:    bottom = cfg_wdata[COORD_BITS-1:0];
          default: ;
        endcase
      end
      // results leaving now belong to older requests, so compare before predicting
      if (rsp.valid && rsp.ready) begin
        got = '{x: rsp.out_x, y: rsp.out_y, buttons: rsp.out_buttons};
        if (expected_pos_q.size() == 0) begin
          $error("result with no request outstanding: x=%0d y=%0d buttons=%0h",
                 got.x, got.y, got.buttons);
          fails++;
        end else begin
          want = expected_pos_q.pop_front();
          if (got.x !== want.x) begin
            $error("out_x: expected %0d, actual %0d", want.x, got.x);
            fails++;
          end
          if (got.y !== want.y) begin
            $error("out_y: expected %0d, actual %0d", want.y, got.y);
            fails++;
          end
          if (got.buttons !== want.buttons) begin
            $error("out_buttons: expected %0h, actual %0h", want.buttons, got.buttons);
            fails++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_pos_q.push_back(advance_pointer(req.req_type, req.move_dx, req.move_dy,
                                                 req.button_bits, req.pos_x, req.pos_y));
    end
    mismatches <= fails;
    pending    <= expected_pos_q.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Top of the pointer_accel_clamp bench: clock, reset, register writes and request stimulus.
// Depends on pac_pkg, the channel interfaces, pac_checker and the block itself.
module tb;
  import pac_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int CFG_W = (COORD_BITS > THRESH_W) ? COORD_BITS : THRESH_W;
  // request code with no defined action; block must leave state alone
  localparam logic [1:0] REQ_HOLD = 2'd3;
  // cycles without any handshake before the run is declared hung
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 300;
  localparam int RANDOM_PHASES = 6;

  typedef struct {
    logic [1:0]                 kind;
    logic signed [MOVE_W-1:0]   dx;
    logic signed [MOVE_W-1:0]   dy;
    logic [BTN_W-1:0]           btn;
    logic signed [COORD_BITS:0] px;
    logic signed [COORD_BITS:0] py;
  } pointer_req_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  calm;          // suppresses idling on both sides
  int                    mismatches;
  int                    pending;
  int                    quiet;
  int                    n_move, n_set, n_center, n_hold, n_settings;

  pac_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
  pac_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_if ();

  pointer_accel_clamp #(.COORD_BITS(COORD_BITS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  pac_checker #(.COORD_BITS(COORD_BITS), .CFG_W(CFG_W)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .req        (req_if),
    .rsp        (rsp_if),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Result side: random back-pressure, ready low about 10 percent of the time, unless in a calm stretch.
  always @(posedge clk) begin
    rsp_if.ready <= calm || ($urandom_range(99) >= 10);
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("pointer_accel_clamp verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --- request builders; fields the request kind ignores get random junk ---
  function automatic pointer_req_t move_req(int dx, int dy, logic [BTN_W-1:0] btn);
    pointer_req_t r;
    r.kind = REQ_MOVE;
    r.dx   = MOVE_W'(dx);
    r.dy   = MOVE_W'(dy);
    r.btn  = btn;
    r.px   = (COORD_BITS+1)'($urandom);
    r.py   = (COORD_BITS+1)'($urandom);
    return r;
  endfunction

  function automatic pointer_req_t set_req(int px, int py);
    pointer_req_t r;
    r.kind = REQ_SET;
    r.dx   = MOVE_W'($urandom);
    r.dy   = MOVE_W'($urandom);
    r.btn  = BTN_W'($urandom);
    r.px   = (COORD_BITS+1)'(px);
    r.py   = (COORD_BITS+1)'(py);
    return r;
  endfunction

  function automatic pointer_req_t junk_req(logic [1:0] kind);
    pointer_req_t r;
    r      = set_req($urandom, $urandom);
    r.kind = kind;
    return r;
  endfunction

  // Mostly moves; deltas mostly small so the pointer wanders inside the limits,
  // a third full range to hit the acceleration and the clamps.
  function automatic pointer_req_t random_req();
    int sel;
    int dx, dy;
    sel = $urandom_range(99);
    if (sel < 60) begin
      if ($urandom_range(2) == 0) begin
        dx = $signed(MOVE_W'($urandom));
        dy = $signed(MOVE_W'($urandom));
      end else begin
        dx = int'($urandom_range(48)) - 24;
        dy = int'($urandom_range(48)) - 24;
      end
      return move_req(dx, dy, BTN_W'($urandom));
    end
    if (sel < 78) begin
      if ($urandom_range(1) == 0)
        return set_req($signed((COORD_BITS+1)'($urandom)), $signed((COORD_BITS+1)'($urandom)));
      return set_req($urandom_range(4095), $urandom_range(4095));
    end
    if (sel < 92)
      return junk_req(REQ_CENTER);
    return junk_req(REQ_HOLD);
  endfunction

  // Drive one request and hold it until the block takes it.
  task automatic issue(pointer_req_t r);
    while (!calm && $urandom_range(99) < 10) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.kind;
    req_if.move_dx     <= r.dx;
    req_if.move_dy     <= r.dy;
    req_if.button_bits <= r.btn;
    req_if.pos_x       <= r.px;
    req_if.pos_y       <= r.py;
    do @(posedge clk); while (!req_if.ready);
    case (r.kind)
      REQ_MOVE:   n_move++;
      REQ_SET:    n_set++;
      REQ_CENTER: n_center++;
      default:    n_hold++;
    endcase
  endtask

  // Drop valid and wait until every request has its result, then idle before returning.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic poke(cfg_reg_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic load_cfg(logic [GAIN_W-1:0] gain, logic [THRESH_W-1:0] thr,
                          logic [COORD_BITS-1:0] l, logic [COORD_BITS-1:0] r,
                          logic [COORD_BITS-1:0] t, logic [COORD_BITS-1:0] b);
    poke(CFG_GAIN, CFG_W'(gain));
    poke(CFG_THRESHOLD, CFG_W'(thr));
    poke(CFG_LEFT, CFG_W'(l));
    poke(CFG_RIGHT, CFG_W'(r));
    poke(CFG_TOP, CFG_W'(t));
    poke(CFG_BOTTOM, CFG_W'(b));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Random setting: gain may be zero, thresholds often small so acceleration
  // kicks in; limits ordered three times in four, otherwise possibly crossed.
  task automatic random_cfg();
    logic [COORD_BITS-1:0] a, b, c, d, s;
    a = COORD_BITS'($urandom);
    b = COORD_BITS'($urandom);
    c = COORD_BITS'($urandom);
    d = COORD_BITS'($urandom);
    if ($urandom_range(3) != 0) begin
      if (a > b) begin s = a; a = b; b = s; end
      if (c > d) begin s = c; c = d; d = s; end
    end
    load_cfg(GAIN_W'($urandom),
             ($urandom_range(1) == 0) ? THRESH_W'($urandom_range(20)) : THRESH_W'($urandom),
             a, b, c, d);
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_GAIN;
    cfg_wdata          <= '0;
    calm               <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_MOVE;
    req_if.move_dx     <= '0;
    req_if.move_dy     <= '0;
    req_if.button_bits <= '0;
    req_if.pos_x       <= '0;
    req_if.pos_y       <= '0;
    n_move = 0; n_set = 0; n_center = 0; n_hold = 0; n_settings = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset defaults: threshold edges, full-scale deltas, clamping
    // on both sides, set and recenter, the undefined code.
    issue(move_req(0, 0, 8'h00));
    issue(move_req(5, -5, 8'hFF));        // exactly at threshold, no boost
    issue(move_req(6, -6, 8'h55));        // one above threshold
    issue(move_req(255, 255, 8'hAA));
    issue(move_req(-256, -256, 8'h0F));   // pushes y below its low limit
    issue(set_req(4095, 4095));           // clamps to the high limits
    issue(set_req(-4096, -4096));
    issue(set_req(700, -1));
    issue(junk_req(REQ_CENTER));
    issue(junk_req(REQ_HOLD));            // state must not move
    issue(move_req(255, -256, 8'hF0));
    issue(set_req(1024, 768));
    settle();

    // Widest limits, no threshold, largest gain: biggest accelerated moves.
    load_cfg(4'd15, 8'd0, 12'd0, 12'd4095, 12'd0, 12'd4095);
    issue(move_req(255, 255, 8'h01));
    issue(move_req(-256, -256, 8'h80));
    issue(move_req(1, -1, 8'h3C));
    issue(junk_req(REQ_CENTER));
    issue(set_req(4095, -4096));
    settle();

    // Crossed limits (upper wins) with zero gain: magnitude saturates at threshold.
    load_cfg(4'd0, 8'd255, 12'd3000, 12'd1000, 12'd4095, 12'd0);
    issue(move_req(255, -256, 8'hC3));
    issue(move_req(-100, 100, 8'h18));
    issue(set_req(2000, 2000));
    issue(junk_req(REQ_CENTER));
    issue(junk_req(REQ_HOLD));
    settle();

    // Random phases, each under its own register setting. The first two are
    // fixed corners; one phase runs with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       load_cfg(4'd1, 8'd1, 12'd2048, 12'd2048, 12'd100, 12'd200);
        1:       load_cfg(4'd15, 8'd255, 12'd0, 12'd4095, 12'd0, 12'd4095);
        default: random_cfg();
      endcase
      calm <= (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++)
        issue(random_req());
      settle();
    end
    calm <= 1'b0;

    $display("covered %0d requests: %0d moves, %0d sets, %0d recenters, %0d undefined codes",
             n_move + n_set + n_center + n_hold, n_move, n_set, n_center, n_hold);
    $display("under %0d register settings plus reset defaults, stalls on both channels",
             n_settings);
    if (mismatches == 0 && pending == 0) begin
      $display("pointer_accel_clamp verification clean");
    end else begin
      $display("pointer_accel_clamp verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/pac_pkg.sv
sv/pac_req_if.sv
sv/pac_rsp_if.sv
sv/pac_cfg_regs.sv
sv/pac_axis.sv
sv/pointer_accel_clamp.sv
dv/pac_checker.sv
dv/tb.sv
